### design/dual_beam_direction_counter_defines.svh
// ----------------------------------------------------------------------------
// Dual-beam direction counter assertion macros
// Assertion wrappers for the RTL. Defining NO_ASSERTIONS removes them.
// ----------------------------------------------------------------------------
`ifndef DUAL_BEAM_DIRECTION_COUNTER_DEFINES_SVH
`define DUAL_BEAM_DIRECTION_COUNTER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define DBDC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DBDC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DBDC_ASSERT_NOW(lbl, ante, cons, msg)
`define DBDC_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

### design/dbdc_pkg.sv
// ----------------------------------------------------------------------------
// Dual-beam direction counter package
// Widths, defaults, register indexes, direction codes and the direction table.
// ----------------------------------------------------------------------------
package dbdc_pkg;

    // Default geometry.
    localparam int PATHS_DEF  = 8;
    localparam int BOARDS_DEF = 8;

    // Field widths.
    localparam int BOARD_W    = 3;
    localparam int SENSOR_W   = 8;
    localparam int TIME_W     = 32;
    localparam int TIMEOUT_W  = 20;
    localparam int CNT_OUT_W  = 4;
    localparam int TOTAL_W    = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Register reset values.
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET    = 20'd5000;
    localparam logic [TIME_W-1:0]    START_TIME_RESET = 32'd0;

    // Saturation limit of the per-transaction counts.
    localparam logic [CNT_OUT_W-1:0] CNT_OUT_MAX = 4'd15;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT_MS = 1'b0,
        CFG_START_TIME = 1'b1
    } t_cfg_idx;

    // Direction status of one path.
    typedef enum logic [1:0] {
        DIR_IDLE = 2'd0,
        DIR_OUT  = 2'd1,
        DIR_IN   = 2'd2
    } t_dir;

    // Result of one table lookup.
    typedef struct packed {
        t_dir dir;
        logic ent;
        logic ext;
    } t_step;

    // Direction table. The unused code behaves like going in.
    function automatic t_step f_step(input logic bi, input logic bo, input logic [1:0] d);
        t_step s;
        logic  is_in;
        is_in = (d != DIR_IDLE) && (d != DIR_OUT);
        s.ent = 1'b0;
        s.ext = 1'b0;
        s.dir = DIR_IDLE;
        unique case ({bi, bo})
            2'b10: begin
                if (is_in) begin
                    s.dir = DIR_IDLE;
                    s.ent = 1'b1;
                end else begin
                    s.dir = DIR_OUT;
                end
            end
            2'b01: begin
                if (d == DIR_OUT) begin
                    s.dir = DIR_IDLE;
                    s.ext = 1'b1;
                end else begin
                    s.dir = DIR_IN;
                end
            end
            2'b11: begin
                if (is_in) begin
                    s.dir = DIR_IN;
                    s.ent = 1'b1;
                end else begin
                    s.dir = DIR_OUT;
                    s.ext = 1'b1;
                end
            end
            default: begin
                // No beam: the caller keeps the stored direction.
                s.dir = t_dir'(d);
            end
        endcase
        return s;
    endfunction

endpackage

### design/dual_beam_direction_counter.sv
// ----------------------------------------------------------------------------
// Dual-beam direction counter
// A transaction passes stage 1, stage 2, stage 3 and the output register.
// Throughput: one transaction per cycle while the output is not held back;
// one board row is read and written back per cycle, with forwarding between
// back-to-back rows of one board. Reset (synchronous, active low) clears all
// paths with per-board valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "dual_beam_direction_counter_defines.svh"

module dual_beam_direction_counter #(
    parameter int PATHS  = dbdc_pkg::PATHS_DEF,
    parameter int BOARDS = dbdc_pkg::BOARDS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration port
    input  logic                                i_cfg_we,
    input  logic [dbdc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dbdc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [dbdc_pkg::BOARD_W-1:0]        i_board_index,
    input  logic [dbdc_pkg::SENSOR_W-1:0]       i_inside_sensors,
    input  logic [dbdc_pkg::SENSOR_W-1:0]       i_outside_sensors,
    input  logic [dbdc_pkg::TIME_W-1:0]         i_event_time,
    // Output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [dbdc_pkg::CNT_OUT_W-1:0]      o_entries,
    output logic [dbdc_pkg::CNT_OUT_W-1:0]      o_exits,
    output logic [dbdc_pkg::CNT_OUT_W-1:0]      o_stale_paths,
    output logic [dbdc_pkg::TOTAL_W-1:0]        o_total_entries,
    output logic [dbdc_pkg::TOTAL_W-1:0]        o_total_exits,
    output logic [dbdc_pkg::TOTAL_W-1:0]        o_total_stale
);
    import dbdc_pkg::*;

    localparam int ADDR_W = (BOARDS > 1) ? $clog2(BOARDS) : 1;
    localparam int IDX_W  = (ADDR_W > BOARD_W) ? ADDR_W : BOARD_W;
    localparam int CNT_W  = $clog2(PATHS + 1);

    // Board rows: per board, one word holds all path directions and one all times.
    logic [PATHS-1:0][1:0]        r_dir_mem  [BOARDS];
    logic [PATHS-1:0][TIME_W-1:0] r_time_mem [BOARDS];

    // Row valid bits: directions are cleared by reset, times also by a
    // start time write.
    logic [BOARDS-1:0]            r_dir_ok;
    logic [BOARDS-1:0]            r_time_ok;

    // Configuration registers.
    logic [TIMEOUT_W-1:0]         r_timeout_ms;
    logic [TIME_W-1:0]            r_start_time;

    // Input mapping.
    logic                         w_advance;
    logic                         w_accept;
    logic                         w_in_range;
    logic [IDX_W-1:0]             w_board_ext;
    logic [ADDR_W-1:0]            w_addr;
    logic [PATHS-1:0]             w_bi;
    logic [PATHS-1:0]             w_bo;

    // Stage 1: row read.
    logic                         r_s1_valid;
    logic                         r_s1_in_range;
    logic                         r_s1_fwd;
    logic [ADDR_W-1:0]            r_s1_addr;
    logic [PATHS-1:0]             r_s1_bi;
    logic [PATHS-1:0]             r_s1_bo;
    logic [TIME_W-1:0]            r_s1_time;
    logic [PATHS-1:0][1:0]        r_rd_dir;
    logic [PATHS-1:0][TIME_W-1:0] r_rd_time;

    // Stage 1: row update.
    logic [PATHS-1:0][1:0]        w_cur_dir;
    logic [PATHS-1:0][TIME_W-1:0] w_cur_time;
    logic [PATHS-1:0][TIME_W-1:0] w_gap;
    logic [PATHS-1:0]             w_trig;
    logic [PATHS-1:0]             w_stale;
    t_step                        w_step [PATHS];
    logic [PATHS-1:0][1:0]        w_new_dir;
    logic [PATHS-1:0][TIME_W-1:0] w_new_time;
    logic [PATHS-1:0]             w_ent;
    logic [PATHS-1:0]             w_ext;
    logic [PATHS-1:0]             w_stl;
    logic                         w_mem_we;

    // Stage 2: updated row and event flags.
    logic                         r_s2_valid;
    logic [PATHS-1:0][1:0]        r_s2_dir;
    logic [PATHS-1:0][TIME_W-1:0] r_s2_time;
    logic [PATHS-1:0]             r_s2_ent;
    logic [PATHS-1:0]             r_s2_ext;
    logic [PATHS-1:0]             r_s2_stl;

    // Stage 3: counts.
    logic                         r_s3_valid;
    logic [CNT_W-1:0]             r_s3_ent;
    logic [CNT_W-1:0]             r_s3_ext;
    logic [CNT_W-1:0]             r_s3_stl;

    // Output register and running totals.
    logic                         r_out_valid;
    logic [CNT_OUT_W-1:0]         r_out_entries;
    logic [CNT_OUT_W-1:0]         r_out_exits;
    logic [CNT_OUT_W-1:0]         r_out_stale;
    logic [TOTAL_W-1:0]           r_total_entries;
    logic [TOTAL_W-1:0]           r_total_exits;
    logic [TOTAL_W-1:0]           r_total_stale;

    // The whole pipeline moves unless a finished result is held back.
    assign w_advance  = !r_out_valid || !i_out_stall;
    assign w_accept   = i_in_valid && w_advance;
    assign o_in_stall = !w_advance;

    // Board address and range check.
    assign w_board_ext = IDX_W'(i_board_index);
    assign w_addr      = w_board_ext[ADDR_W-1:0];
    assign w_in_range  = (32'(i_board_index) < 32'(BOARDS));

    // Beam bits per path; outside bits run in reverse path order.
    for (genvar k = 0; k < PATHS; k++) begin : g_map
        if (k < SENSOR_W) begin : g_in
            assign w_bi[k] = i_inside_sensors[k];
        end else begin : g_in_none
            assign w_bi[k] = 1'b0;
        end
        if (PATHS - 1 - k < SENSOR_W) begin : g_out
            assign w_bo[k] = i_outside_sensors[PATHS-1-k];
        end else begin : g_out_none
            assign w_bo[k] = 1'b0;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ms <= TIMEOUT_RESET;
            r_start_time <= START_TIME_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TIMEOUT_MS: r_timeout_ms <= i_cfg_data[TIMEOUT_W-1:0];
                CFG_START_TIME: r_start_time <= i_cfg_data[TIME_W-1:0];
            endcase
        end
    end

    // Row memories: synchronous read at accept, write-back from stage 1.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_dir  <= r_dir_mem[w_addr];
            r_rd_time <= r_time_mem[w_addr];
        end
        if (w_mem_we) begin
            r_dir_mem[r_s1_addr]  <= w_new_dir;
            r_time_mem[r_s1_addr] <= w_new_time;
        end
    end

    // Row valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_ok  <= '0;
            r_time_ok <= '0;
        end else begin
            if (w_mem_we) begin
                r_dir_ok[r_s1_addr]  <= 1'b1;
                r_time_ok[r_s1_addr] <= 1'b1;
            end
            if (i_cfg_we && (t_cfg_idx'(i_cfg_index) == CFG_START_TIME)) begin
                r_time_ok <= '0;
            end
        end
    end

    // Stage 1 control. Forwarding is chosen when the row still being
    // written back belongs to the same board.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_fwd   <= 1'b0;
        end else if (w_advance) begin
            r_s1_valid <= w_accept;
            r_s1_fwd   <= r_s1_valid && r_s1_in_range && (r_s1_addr == w_addr);
        end
    end

    // Stage 1 payload.
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_s1_in_range <= w_in_range;
            r_s1_addr     <= w_addr;
            r_s1_bi       <= w_bi;
            r_s1_bo       <= w_bo;
            r_s1_time     <= i_event_time;
        end
    end

    // Stage 1 update of every path of the row, side by side.
    always_comb begin
        for (int k = 0; k < PATHS; k++) begin
            if (r_s1_fwd) begin
                w_cur_dir[k]  = r_s2_dir[k];
                w_cur_time[k] = r_s2_time[k];
            end else begin
                w_cur_dir[k]  = r_dir_ok[r_s1_addr] ? r_rd_dir[k] : DIR_IDLE;
                w_cur_time[k] = r_time_ok[r_s1_addr] ? r_rd_time[k] : r_start_time;
            end
            w_trig[k]  = r_s1_bi[k] || r_s1_bo[k];
            w_gap[k]   = r_s1_time - w_cur_time[k];
            w_stale[k] = w_trig[k] && (w_gap[k] > TIME_W'(r_timeout_ms));
            w_step[k]  = f_step(r_s1_bi[k], r_s1_bo[k],
                                w_stale[k] ? DIR_IDLE : w_cur_dir[k]);
            w_new_dir[k]  = w_trig[k] ? w_step[k].dir : w_cur_dir[k];
            w_new_time[k] = w_trig[k] ? r_s1_time : w_cur_time[k];
            w_ent[k] = r_s1_in_range && w_trig[k] && w_step[k].ent;
            w_ext[k] = r_s1_in_range && w_trig[k] && w_step[k].ext;
            w_stl[k] = r_s1_in_range && w_stale[k];
        end
    end

    assign w_mem_we = w_advance && r_s1_valid && r_s1_in_range;

    // Stage 2 registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_advance) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_s2_dir  <= w_new_dir;
            r_s2_time <= w_new_time;
            r_s2_ent  <= w_ent;
            r_s2_ext  <= w_ext;
            r_s2_stl  <= w_stl;
        end
    end

    // Stage 3: count the flags of the transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_advance) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_s3_ent <= CNT_W'($countones(r_s2_ent));
            r_s3_ext <= CNT_W'($countones(r_s2_ext));
            r_s3_stl <= CNT_W'($countones(r_s2_stl));
        end
    end

    // Output register and running totals.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid     <= 1'b0;
            r_total_entries <= '0;
            r_total_exits   <= '0;
            r_total_stale   <= '0;
        end else if (w_advance) begin
            r_out_valid <= r_s3_valid;
            if (r_s3_valid) begin
                r_total_entries <= r_total_entries + TOTAL_W'(r_s3_ent);
                r_total_exits   <= r_total_exits + TOTAL_W'(r_s3_ext);
                r_total_stale   <= r_total_stale + TOTAL_W'(r_s3_stl);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_entries <= (32'(r_s3_ent) > 32'(CNT_OUT_MAX)) ? CNT_OUT_MAX
                                                                : CNT_OUT_W'(r_s3_ent);
            r_out_exits   <= (32'(r_s3_ext) > 32'(CNT_OUT_MAX)) ? CNT_OUT_MAX
                                                                : CNT_OUT_W'(r_s3_ext);
            r_out_stale   <= (32'(r_s3_stl) > 32'(CNT_OUT_MAX)) ? CNT_OUT_MAX
                                                                : CNT_OUT_W'(r_s3_stl);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_entries       = r_out_entries;
    assign o_exits         = r_out_exits;
    assign o_stale_paths   = r_out_stale;
    assign o_total_entries = r_total_entries;
    assign o_total_exits   = r_total_exits;
    assign o_total_stale   = r_total_stale;

    // A row never has valid times without valid directions.
    `DBDC_ASSERT_NOW(a_time_ok_subset, 1'b1, (r_time_ok & ~r_dir_ok) == '0, "time valid without direction valid")

    // A written row is marked valid on the next cycle.
    `DBDC_ASSERT_NXT(a_row_valid_after_write, w_mem_we, r_dir_ok[$past(r_s1_addr)], "written row not valid")

    // The entry total only moves when a counted transaction leaves stage 3.
    `DBDC_ASSERT_NOW(a_totals_move, r_total_entries != $past(r_total_entries), $past(w_advance && r_s3_valid), "entry total changed without a transaction")

    // Each path yields at most one entry or exit per transaction.
    `DBDC_ASSERT_NOW(a_count_bound, o_out_valid, (32'(o_entries) + 32'(o_exits)) <= 32'(PATHS), "more entries and exits than paths")

endmodule

### verif/tb_dual_beam_direction_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual-beam direction counter testbench
// Feeds board snapshots through the valid/stall input channel and checks
// every result transaction against a cycle-free predictor of the path
// directions, stale resets and running totals. Both channels idle at random.
// A long receiver hold-off backs the pipeline up into the input. The timeout
// and start time registers are rewritten between phases.
// ----------------------------------------------------------------------------
module tb_dual_beam_direction_counter;
    import dbdc_pkg::*;

    localparam int NPATH  = PATHS_DEF;
    localparam int NBOARD = BOARDS_DEF;

    // One input snapshot and one result transaction.
    typedef struct packed {
        logic [BOARD_W-1:0]  board;
        logic [SENSOR_W-1:0] inner;
        logic [SENSOR_W-1:0] outside;
        logic [TIME_W-1:0]   stamp;
    } t_snapshot;

    typedef struct packed {
        logic [CNT_OUT_W-1:0] entries;
        logic [CNT_OUT_W-1:0] exits;
        logic [CNT_OUT_W-1:0] stale;
        logic [TOTAL_W-1:0]   tot_ent;
        logic [TOTAL_W-1:0]   tot_ext;
        logic [TOTAL_W-1:0]   tot_stale;
    } t_tally;

    // Block ports.
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [BOARD_W-1:0]    i_board_index = '0;
    logic [SENSOR_W-1:0]   i_inside_sensors = '0;
    logic [SENSOR_W-1:0]   i_outside_sensors = '0;
    logic [TIME_W-1:0]     i_event_time = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [CNT_OUT_W-1:0]  o_entries;
    logic [CNT_OUT_W-1:0]  o_exits;
    logic [CNT_OUT_W-1:0]  o_stale_paths;
    logic [TOTAL_W-1:0]    o_total_entries;
    logic [TOTAL_W-1:0]    o_total_exits;
    logic [TOTAL_W-1:0]    o_total_stale;

    // Predicted state of the paths and the registers.
    t_dir               path_dir [NBOARD*NPATH];
    logic [TIME_W-1:0]  path_seen [NBOARD*NPATH];
    logic [TIMEOUT_W-1:0] timeout_q;
    logic [TIME_W-1:0]  start_q;
    logic [TOTAL_W-1:0] sum_ent;
    logic [TOTAL_W-1:0] sum_ext;
    logic [TOTAL_W-1:0] sum_stale;

    // Snapshots waiting to be sent and results waiting to arrive.
    t_snapshot snap_queue [$];
    t_tally    tally_queue [$];

    logic        snap_taken = 1'b0;
    logic        result_taken = 1'b0;
    logic        no_idle = 1'b0;
    int unsigned feed_gap = 0;
    int unsigned drain_wait = 0;
    int unsigned hold_left = 0;
    int unsigned hold_cool = 0;
    int unsigned holds_done = 0;
    int unsigned mismatch_cnt = 0;
    logic [TIME_W-1:0] stim_clock;

    dual_beam_direction_counter u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_board_index     (i_board_index),
        .i_inside_sensors  (i_inside_sensors),
        .i_outside_sensors (i_outside_sensors),
        .i_event_time      (i_event_time),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_entries         (o_entries),
        .o_exits           (o_exits),
        .o_stale_paths     (o_stale_paths),
        .o_total_entries   (o_total_entries),
        .o_total_exits     (o_total_exits),
        .o_total_stale     (o_total_stale)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void reset_model();
        timeout_q = TIMEOUT_RESET;
        start_q   = START_TIME_RESET;
        foreach (path_dir[i]) begin
            path_dir[i]  = DIR_IDLE;
            path_seen[i] = START_TIME_RESET;
        end
        sum_ent   = '0;
        sum_ext   = '0;
        sum_stale = '0;
    endfunction

    // A start time write also reloads every last-seen time.
    function automatic void apply_register(input t_cfg_idx idx,
                                           input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_TIMEOUT_MS: begin
                timeout_q = data[TIMEOUT_W-1:0];
            end
            CFG_START_TIME: begin
                start_q = data[TIME_W-1:0];
                foreach (path_seen[i]) path_seen[i] = data[TIME_W-1:0];
            end
            default: begin
            end
        endcase
    endfunction

    // Works out the result of one snapshot and updates the path state.
    // A 3-bit board index always names an existing board.
    function automatic t_tally predict_snapshot(input t_snapshot s);
        t_tally            r;
        int unsigned       n_ent;
        int unsigned       n_ext;
        int unsigned       n_stl;
        int                slot;
        logic              bi;
        logic              bo;
        logic              going_in;
        logic [TIME_W-1:0] gap;
        t_dir              d;
        n_ent = 0;
        n_ext = 0;
        n_stl = 0;
        for (int k = 0; k < NPATH; k++) begin
            slot = int'(s.board) * NPATH + k;
            bi   = s.inner[k];
            bo   = s.outside[NPATH-1-k];
            if (bi || bo) begin
                // Stale check happens once per path, even with both beams.
                gap = s.stamp - path_seen[slot];
                if (gap > {{(TIME_W-TIMEOUT_W){1'b0}}, timeout_q}) begin
                    path_dir[slot] = DIR_IDLE;
                    n_stl++;
                end
                path_seen[slot] = s.stamp;
                d = path_dir[slot];
                // Any code other than idle or going out acts as going in.
                going_in = (d != DIR_IDLE) && (d != DIR_OUT);
                if (bi && bo) begin
                    if (going_in) begin
                        d = DIR_IN;
                        n_ent++;
                    end else begin
                        d = DIR_OUT;
                        n_ext++;
                    end
                end else if (bi) begin
                    if (going_in) begin
                        d = DIR_IDLE;
                        n_ent++;
                    end else begin
                        d = DIR_OUT;
                    end
                end else begin
                    if (d == DIR_OUT) begin
                        d = DIR_IDLE;
                        n_ext++;
                    end else begin
                        d = DIR_IN;
                    end
                end
                path_dir[slot] = d;
            end
        end
        sum_ent   = sum_ent + n_ent[TOTAL_W-1:0];
        sum_ext   = sum_ext + n_ext[TOTAL_W-1:0];
        sum_stale = sum_stale + n_stl[TOTAL_W-1:0];
        // Per-snapshot counts saturate while the totals take the full count.
        r.entries   = (n_ent > CNT_OUT_MAX) ? CNT_OUT_MAX : n_ent[CNT_OUT_W-1:0];
        r.exits     = (n_ext > CNT_OUT_MAX) ? CNT_OUT_MAX : n_ext[CNT_OUT_W-1:0];
        r.stale     = (n_stl > CNT_OUT_MAX) ? CNT_OUT_MAX : n_stl[CNT_OUT_W-1:0];
        r.tot_ent   = sum_ent;
        r.tot_ext   = sum_ext;
        r.tot_stale = sum_stale;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic int unsigned draw_idle();
        return no_idle ? 0 : $urandom_range(0, 11);
    endfunction

    // Outside bit j belongs to path NPATH-1-j.
    function automatic logic [SENSOR_W-1:0] mirror_paths(input logic [SENSOR_W-1:0] m);
        logic [SENSOR_W-1:0] r;
        r = '0;
        for (int k = 0; k < NPATH; k++) r[NPATH-1-k] = m[k];
        return r;
    endfunction

    function automatic void add_snapshot(input int b, input logic [SENSOR_W-1:0] ins,
                                         input logic [SENSOR_W-1:0] outs,
                                         input logic [TIME_W-1:0] t);
        t_snapshot s;
        s.board   = b[BOARD_W-1:0];
        s.inner   = ins;
        s.outside = outs;
        s.stamp   = t;
        snap_queue = {snap_queue, s};
    endfunction

    // Mostly small steps, sometimes past the timeout, rarely anywhere at all.
    function automatic void advance_clock(input int unsigned step_max);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
            stim_clock = stim_clock + $urandom_range(0, 2 * timeout_q + 20);
        end else if (roll < 6) begin
            stim_clock = $urandom;
        end else begin
            stim_clock = stim_clock + $urandom_range(0, step_max);
        end
    endfunction

    // Mostly people crossing a set of paths in either direction, with noise.
    function automatic void random_phase(input int n_items, input int unsigned step_max);
        int                  made;
        int unsigned         roll;
        int                  b;
        logic                going_in;
        logic [SENSOR_W-1:0] m;
        made = 0;
        while (made < n_items) begin
            roll = $urandom_range(0, 9);
            b    = $urandom_range(0, NBOARD - 1);
            m    = SENSOR_W'($urandom_range(1, 255));
            advance_clock(step_max);
            if (roll < 7) begin
                going_in = roll[0];
                add_snapshot(b, going_in ? '0 : m, going_in ? mirror_paths(m) : '0,
                             stim_clock);
                if (roll < 3) begin
                    advance_clock(step_max);
                    add_snapshot(b, m, mirror_paths(m), stim_clock);
                    made++;
                end
                advance_clock(step_max);
                add_snapshot(b, going_in ? m : '0, going_in ? '0 : mirror_paths(m),
                             stim_clock);
                made += 2;
            end else begin
                add_snapshot(b, SENSOR_W'($urandom_range(0, 255)),
                             SENSOR_W'($urandom_range(0, 255)), stim_clock);
                made++;
            end
        end
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    // Returns at a falling edge once every sent transaction has come back.
    task automatic wait_until_idle();
        do @(posedge i_clk);
        while (snap_queue.size() != 0 || i_in_valid || tally_queue.size() != 0);
        repeat (6) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Input driver: one snapshot per transaction, random gaps in between.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : feed_snapshots
        t_snapshot   s;
        logic [31:0] junk;
        if (i_rst_n && (!i_in_valid || snap_taken)) begin
            if (feed_gap == 0 && snap_queue.size() != 0) begin
                s = snap_queue.pop_front();
                i_board_index     <= s.board;
                i_inside_sensors  <= s.inner;
                i_outside_sensors <= s.outside;
                i_event_time      <= s.stamp;
                i_in_valid        <= 1'b1;
                feed_gap = draw_idle();
            end else begin
                if (feed_gap != 0) feed_gap--;
                // The payload is meaningless while valid is low.
                junk = $urandom;
                i_board_index     <= junk[2:0];
                i_inside_sensors  <= junk[10:3];
                i_outside_sensors <= junk[18:11];
                i_event_time      <= $urandom;
                i_in_valid        <= 1'b0;
            end
        end
        snap_taken = 1'b0;
    end

    // Output stall: a random wait after each result, plus the long hold-off.
    always @(negedge i_clk) begin : drain_results
        if (result_taken) begin
            drain_wait   = draw_idle();
            result_taken = 1'b0;
        end
        if (drain_wait != 0) begin
            drain_wait--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= (hold_left != 0);
        end
    end

    // Long hold-off on the output while plenty of snapshots are still queued.
    always @(posedge i_clk) begin : long_hold
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_done < 2 && snap_queue.size() > 100 && hold_cool > 2000) begin
            hold_left  <= 400;
            holds_done <= holds_done + 1;
        end
        if (hold_left != 0) begin
            hold_cool <= 0;
        end else begin
            hold_cool <= hold_cool + 1;
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard: results are checked before this edge's input is predicted.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : scoreboard
        t_tally    got;
        t_tally    want;
        t_tally    pred;
        t_snapshot s;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                result_taken = 1'b1;
                got = {o_entries, o_exits, o_stale_paths,
                       o_total_entries, o_total_exits, o_total_stale};
                if (tally_queue.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: result transaction with nothing pending", $realtime);
                end else begin
                    want = tally_queue.pop_front();
                    if (got.entries !== want.entries || got.exits !== want.exits ||
                        got.stale !== want.stale || got.tot_ent !== want.tot_ent ||
                        got.tot_ext !== want.tot_ext || got.tot_stale !== want.tot_stale) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("%0t: mismatch, expected ent %0d ext %0d stale %0d %s",
                                     $realtime, want.entries, want.exits, want.stale,
                                     "and totals below");
                            $display("    expected totals %0d/%0d/%0d",
                                     want.tot_ent, want.tot_ext, want.tot_stale);
                            $display("    got ent %0d ext %0d stale %0d totals %0d/%0d/%0d",
                                     got.entries, got.exits, got.stale,
                                     got.tot_ent, got.tot_ext, got.tot_stale);
                        end
                    end
                end
            end
            if (i_cfg_we)
                apply_register(t_cfg_idx'(i_cfg_index), i_cfg_data);
            if (i_in_valid && !o_in_stall) begin
                snap_taken = 1'b1;
                s = {i_board_index, i_inside_sensors, i_outside_sensors, i_event_time};
                pred = predict_snapshot(s);
                tally_queue = {tally_queue, pred};
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : run_phases
        logic [TIME_W-1:0] t0;
        reset_model();
        stim_clock = '0;

        // Directed: each table entry, full boards, stale edges and time wrap.
        add_snapshot(0, 8'h01, 8'h00, 32'd10);
        add_snapshot(0, 8'h00, 8'h80, 32'd20);
        add_snapshot(7, 8'h00, 8'h01, 32'd30);
        add_snapshot(7, 8'h80, 8'h00, 32'd40);
        add_snapshot(3, 8'hFF, 8'hFF, 32'd50);
        add_snapshot(3, 8'hFF, 8'hFF, 32'd60);
        add_snapshot(3, 8'h00, 8'hFF, 32'd70);
        add_snapshot(3, 8'h00, 8'hFF, 32'd80);
        add_snapshot(3, 8'hFF, 8'hFF, 32'd90);
        add_snapshot(3, 8'hFF, 8'h00, 32'd100);
        add_snapshot(2, 8'h00, 8'h00, 32'd110);
        // A gap equal to the timeout is not stale, one more is.
        add_snapshot(0, 8'h01, 8'h00, 32'd5020);
        add_snapshot(0, 8'h01, 8'h00, 32'd10021);
        // Both beams on stale paths, then the clock wrapping past zero.
        add_snapshot(5, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        add_snapshot(5, 8'hAA, 8'h55, 32'd0);
        add_snapshot(6, 8'h55, 8'hAA, 32'd0);
        add_snapshot(1, 8'h0F, 8'h0F, 32'd5);
        add_snapshot(4, 8'hF0, 8'hF0, 32'd5);
        add_snapshot(1, 8'hF0, 8'hF0, 32'd6);

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait_until_idle();

        // Zero timeout and the highest start time, with no idling at all.
        write_reg(CFG_TIMEOUT_MS, 32'd0);
        write_reg(CFG_START_TIME, 32'hFFFF_FFFF);
        add_snapshot(1, 8'hFF, 8'h00, 32'hFFFF_FFFF);
        add_snapshot(1, 8'hFF, 8'h00, 32'd0);
        no_idle    = 1'b1;
        stim_clock = 32'hFFFF_FFF0;
        random_phase(150, 3);
        wait_until_idle();
        no_idle = 1'b0;

        // Largest timeout.
        t0 = $urandom;
        write_reg(CFG_TIMEOUT_MS, 32'd1_000_000);
        write_reg(CFG_START_TIME, t0);
        stim_clock = t0;
        random_phase(250, 50000);
        wait_until_idle();

        // Short timeout, so paths go stale often.
        t0 = $urandom;
        write_reg(CFG_TIMEOUT_MS, $urandom_range(0, 300));
        write_reg(CFG_START_TIME, t0);
        stim_clock = t0;
        random_phase(250, 100);
        wait_until_idle();

        // Random timeout from zero to one million.
        write_reg(CFG_TIMEOUT_MS, $urandom_range(0, 1_000_000));
        write_reg(CFG_START_TIME, 32'd0);
        stim_clock = '0;
        random_phase(250, timeout_q / 2 + 10);
        wait_until_idle();

        repeat (10) @(negedge i_clk);
        if (mismatch_cnt == 0 && tally_queue.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog.
    initial begin : watchdog
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
